// ----- rtl/html_entity_preserving_escaper_macros.svh -----
// Assertion macros for the HTML entity-preserving escaper.
// Included by the top level; it needs no other file.
`ifndef HTML_ENTITY_PRESERVING_ESCAPER_MACROS_SVH
`define HTML_ENTITY_PRESERVING_ESCAPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HEPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HEPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hepe_pkg.sv -----
// Shared types, character codes and output string helpers of the escaper.
// No dependencies; the front end, the back end and the top level import it.
`timescale 1ns / 1ps

package hepe_pkg;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;

  // Depth of the command queue between the front end and the back end.
  localparam int unsigned FIFO_DEPTH = 2;

  // What a command emits after the optional "amp;" and the replayed bytes.
  typedef enum logic [2:0] {
    TAIL_NONE,
    TAIL_RAW,
    TAIL_LT,
    TAIL_GT,
    TAIL_QUOT,
    TAIL_AMP,
    TAIL_AMP_FULL
  } tail_e;

  typedef struct packed {
    logic       pre_amp;
    tail_e      tail;
    logic [7:0] tail_byte;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic scan_idle;
    logic replay_pend;
  } front_stat_t;

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic [7:0] pre_char(logic [1:0] pos);
    logic [3:0][7:0] str;
    str = "amp;";
    return str[2'd3 - pos];
  endfunction

  function automatic logic [7:0] tail_char(tail_e t, logic [7:0] b, logic [2:0] pos);
    logic [5:0][7:0] str;
    logic [7:0]      res;
    str = '0;
    res = b;
    unique case (t)
      TAIL_LT:       str = {"&lt;", 16'h0000};
      TAIL_GT:       str = {"&gt;", 16'h0000};
      TAIL_QUOT:     str = "&quot;";
      TAIL_AMP:      str = {"&", 40'h0};
      TAIL_AMP_FULL: str = {"&amp;", 8'h00};
      default:       str = '0;
    endcase
    if ((t != TAIL_RAW) && (t != TAIL_NONE)) begin
      res = str[3'd5 - pos];
    end
    return res;
  endfunction

  // Position of the final character of a tail string.
  function automatic logic [2:0] tail_last(tail_e t);
    logic [2:0] res;
    unique case (t)
      TAIL_LT, TAIL_GT: res = 3'd3;
      TAIL_QUOT:        res = 3'd5;
      TAIL_AMP_FULL:    res = 3'd4;
      default:          res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/hepe_stream_if.sv -----
// Valid/ready stream interfaces for the input and output words of the escaper.
// No dependencies.
`timescale 1ns / 1ps

interface hepe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_last;

  modport source (output valid, output in_byte, output string_last, input ready);
  modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface

interface hepe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

// ----- rtl/hepe_cmd_fifo.sv -----
// Short first-in first-out queue that carries commands from front to back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module hepe_cmd_fifo #(
  parameter int unsigned WIDTH = 19,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/hepe_front.sv -----
// Front end: accepts input words, tracks the entity scan, holds candidate bytes
// and issues one command per word that yields output. Uses hepe_pkg, hepe_in_if.
`timescale 1ns / 1ps

module hepe_front
  import hepe_pkg::*;
#(
  parameter int unsigned ENTITY_WINDOW = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  hepe_in_if.sink                                in_i,
  input  logic                                   fifo_full_i,
  input  logic                                   replay_done_i,
  input  logic [$clog2(ENTITY_WINDOW)-1:0]       rd_idx_i,
  output logic [7:0]                             rd_byte_o,
  output logic                                   push_o,
  output cmd_t                                   cmd_o,
  output logic [$clog2(ENTITY_WINDOW + 1)-1:0]   rep_o,
  output front_stat_t                            stat_o
);

  localparam int unsigned IDX_W = $clog2(ENTITY_WINDOW);
  localparam int unsigned CNT_W = $clog2(ENTITY_WINDOW + 1);
  localparam int unsigned K_W   = $clog2(ENTITY_WINDOW + 2);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ALPHA = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_HASHW = 2'd3;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_HOLD = 2'd1;
  localparam logic [1:0] ACT_ENT  = 2'd2;
  localparam logic [1:0] ACT_BRK  = 2'd3;

  logic [7:0]       held_q [ENTITY_WINDOW];
  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;

  logic [7:0]       b;
  logic             last;
  logic             accept;
  logic [K_W-1:0]   k;
  logic             k_lt_w;
  logic             k_eq_w;
  logic             semi_ok;
  logic [1:0]       act;
  logic [1:0]       hold_phase;
  logic             wr_en;
  logic             fresh;

  assign b         = in_i.in_byte;
  assign last      = in_i.string_last;
  assign in_i.ready = !pend_q && !fifo_full_i;
  assign accept    = in_i.valid && in_i.ready;

  // Offset of this byte from the pending ampersand.
  assign k       = K_W'(cnt_q) + K_W'(1);
  assign k_lt_w  = (k < K_W'(ENTITY_WINDOW));
  assign k_eq_w  = (k == K_W'(ENTITY_WINDOW));
  assign semi_ok = (k > K_W'(2)) && (k <= K_W'(ENTITY_WINDOW));

  // Classify the byte against the scan.
  always_comb begin
    act        = ACT_NONE;
    hold_phase = phase_q;
    unique case (phase_q)
      PH_ALPHA: begin
        if (k_lt_w && is_letter(b)) begin
          act = ACT_HOLD;
        end else if (b == CH_SEMI) begin
          act = semi_ok ? ACT_ENT : ACT_BRK;
        end else if ((b == CH_HASH) && k_lt_w) begin
          act        = ACT_HOLD;
          hold_phase = PH_DIGIT;
        end else if ((b == CH_HASH) && k_eq_w) begin
          act        = ACT_HOLD;
          hold_phase = PH_HASHW;
        end else begin
          act = ACT_BRK;
        end
      end
      PH_DIGIT: begin
        if (k_lt_w && is_digit(b)) begin
          act = ACT_HOLD;
        end else if (b == CH_SEMI) begin
          act = semi_ok ? ACT_ENT : ACT_BRK;
        end else begin
          act = ACT_BRK;
        end
      end
      PH_HASHW: act = (b == CH_SEMI) ? ACT_ENT : ACT_BRK;
      default:  act = ACT_NONE;
    endcase
  end

  always_comb begin
    push_o          = 1'b0;
    cmd_o.pre_amp   = 1'b0;
    cmd_o.tail      = TAIL_NONE;
    cmd_o.tail_byte = b;
    cmd_o.last      = last;
    rep_o           = '0;
    phase_d         = phase_q;
    cnt_d           = cnt_q;
    wr_en           = 1'b0;
    fresh           = 1'b0;
    if (accept) begin
      unique case (act)
        ACT_HOLD: begin
          wr_en = 1'b1;
          if (last) begin
            // The string ends inside a scan: flush everything held.
            push_o        = 1'b1;
            cmd_o.pre_amp = 1'b1;
            rep_o         = cnt_q + CNT_W'(1);
            phase_d       = PH_IDLE;
            cnt_d         = '0;
          end else begin
            phase_d = hold_phase;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        ACT_ENT: begin
          push_o     = 1'b1;
          rep_o      = cnt_q;
          cmd_o.tail = TAIL_RAW;
          phase_d    = PH_IDLE;
          cnt_d      = '0;
        end
        ACT_BRK: begin
          push_o        = 1'b1;
          cmd_o.pre_amp = 1'b1;
          rep_o         = cnt_q;
          fresh         = 1'b1;
          phase_d       = PH_IDLE;
          cnt_d         = '0;
        end
        default: begin
          push_o = 1'b1;
          fresh  = 1'b1;
        end
      endcase
      if (fresh) begin
        priority if (b == CH_AMP) begin
          if (last) begin
            cmd_o.tail = TAIL_AMP_FULL;
          end else begin
            cmd_o.tail = TAIL_AMP;
            phase_d    = PH_ALPHA;
            cnt_d      = '0;
          end
        end else if (b == CH_LT) begin
          cmd_o.tail = TAIL_LT;
        end else if (b == CH_GT) begin
          cmd_o.tail = TAIL_GT;
        end else if (b == CH_QUOT) begin
          cmd_o.tail = TAIL_QUOT;
        end else begin
          cmd_o.tail = TAIL_RAW;
        end
      end
    end
  end

  // A replay command locks the hold buffer until the back end has read it.
  always_comb begin
    pend_d = pend_q;
    if (replay_done_i) begin
      pend_d = 1'b0;
    end
    if (push_o && (rep_o != '0)) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      held_q[cnt_q[IDX_W-1:0]] <= b;
    end
  end

  assign rd_byte_o          = held_q[rd_idx_i];
  assign stat_o.scan_idle   = (phase_q == PH_IDLE);
  assign stat_o.replay_pend = pend_q;

endmodule

// ----- rtl/hepe_back.sv -----
// Back end: runs the command at the queue head one output word per cycle unless
// out_o stalls, and drives the registered output channel. Uses hepe_pkg, hepe_out_if.
`timescale 1ns / 1ps

module hepe_back
  import hepe_pkg::*;
#(
  parameter int unsigned ENTITY_WINDOW = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  input  cmd_t                                   cmd_i,
  input  logic [$clog2(ENTITY_WINDOW + 1)-1:0]   rep_i,
  output logic                                   pop_o,
  output logic [$clog2(ENTITY_WINDOW)-1:0]       rd_idx_o,
  input  logic [7:0]                             rd_byte_i,
  output logic                                   replay_done_o,
  hepe_out_if.source                             out_o
);

  localparam int unsigned IDX_W = $clog2(ENTITY_WINDOW);
  localparam int unsigned CNT_W = $clog2(ENTITY_WINDOW + 1);

  localparam logic [1:0] SEG_START = 2'd0;
  localparam logic [1:0] SEG_PRE   = 2'd1;
  localparam logic [1:0] SEG_REP   = 2'd2;
  localparam logic [1:0] SEG_TAIL  = 2'd3;

  logic [1:0]       seg_q, seg_d;
  logic [2:0]       pos_q, pos_d;
  logic [CNT_W-1:0] ri_q, ri_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q;
  logic             rl_q;
  logic             se_q;

  logic [1:0]       cur_seg;
  logic [1:0]       nxt_seg;
  logic [2:0]       pos_nx;
  logic [CNT_W-1:0] ri_nx;
  logic [7:0]       byte_nx;
  logic             fin;
  logic             rep_end;
  logic             has_tail;
  logic             emit;

  assign has_tail = (cmd_i.tail != TAIL_NONE);
  assign emit     = q_valid_i && (!ov_q || out_o.ready);

  // A fresh command starts at its first non-empty segment.
  always_comb begin
    cur_seg = seg_q;
    if (seg_q == SEG_START) begin
      if (cmd_i.pre_amp) begin
        cur_seg = SEG_PRE;
      end else if (rep_i != '0) begin
        cur_seg = SEG_REP;
      end else begin
        cur_seg = SEG_TAIL;
      end
    end
  end

  always_comb begin
    nxt_seg = cur_seg;
    pos_nx  = pos_q;
    ri_nx   = ri_q;
    fin     = 1'b0;
    rep_end = 1'b0;
    unique case (cur_seg)
      SEG_PRE: begin
        byte_nx = pre_char(pos_q[1:0]);
        if (pos_q == 3'd3) begin
          pos_nx = '0;
          if (rep_i != '0) begin
            nxt_seg = SEG_REP;
          end else if (has_tail) begin
            nxt_seg = SEG_TAIL;
          end else begin
            fin = 1'b1;
          end
        end else begin
          pos_nx = pos_q + 3'd1;
        end
      end
      SEG_REP: begin
        byte_nx = rd_byte_i;
        if (ri_q == (rep_i - CNT_W'(1))) begin
          rep_end = 1'b1;
          ri_nx   = '0;
          if (has_tail) begin
            nxt_seg = SEG_TAIL;
          end else begin
            fin = 1'b1;
          end
        end else begin
          ri_nx = ri_q + CNT_W'(1);
        end
      end
      default: begin
        byte_nx = tail_char(cmd_i.tail, cmd_i.tail_byte, pos_q);
        if (pos_q == tail_last(cmd_i.tail)) begin
          fin = 1'b1;
        end else begin
          pos_nx = pos_q + 3'd1;
        end
      end
    endcase
  end

  always_comb begin
    seg_d = seg_q;
    pos_d = pos_q;
    ri_d  = ri_q;
    ov_d  = ov_q;
    if (emit) begin
      ov_d = 1'b1;
      if (fin) begin
        seg_d = SEG_START;
        pos_d = '0;
        ri_d  = '0;
      end else begin
        seg_d = nxt_seg;
        pos_d = pos_nx;
        ri_d  = ri_nx;
      end
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEG_START;
      pos_q <= '0;
      ri_q  <= '0;
      ov_q  <= 1'b0;
    end else begin
      seg_q <= seg_d;
      pos_q <= pos_d;
      ri_q  <= ri_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ob_q <= byte_nx;
      rl_q <= fin;
      se_q <= fin && cmd_i.last;
    end
  end

  assign pop_o            = emit && fin;
  assign replay_done_o    = emit && rep_end;
  assign rd_idx_o         = ri_q[IDX_W-1:0];
  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = ob_q;
  assign out_o.run_last   = rl_q;
  assign out_o.string_end = se_q;

endmodule

// ----- rtl/html_entity_preserving_escaper.sv -----
// Top level of the HTML entity-preserving escaper: front end, command queue,
// back end. Uses hepe_pkg, the stream interfaces and the assertion macros.
`timescale 1ns / 1ps
`include "html_entity_preserving_escaper_macros.svh"

// Channel   Direction  Word fields                         Handshake
// in_i      in         in_byte[7:0], string_last           valid / ready
// out_o     out        out_byte[7:0], run_last, string_end valid / ready
//
// The back end emits one output word per cycle unless out_o stalls it.
// After a word that replays held bytes, input waits until the last one has been read.
// Reset (rst_ni low, asynchronous) empties the queue and the output register and
// idles the scan; the hold buffer is not cleared. Output stalls fill the two-entry
// queue, then drop in_i.ready.

module html_entity_preserving_escaper
  import hepe_pkg::*;
#(
  parameter int unsigned ENTITY_WINDOW = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hepe_in_if.sink     in_i,
  hepe_out_if.source  out_o
);

  localparam int unsigned IDX_W   = $clog2(ENTITY_WINDOW);
  localparam int unsigned CNT_W   = $clog2(ENTITY_WINDOW + 1);
  localparam int unsigned ENTRY_W = $bits(cmd_t) + CNT_W;

  // Command issued by the front end for a word that yields output.
  logic             push;
  cmd_t             push_cmd;
  logic [CNT_W-1:0] push_rep;

  // Queue head seen by the back end.
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [ENTRY_W-1:0] q_head;
  cmd_t             head_cmd;
  logic [CNT_W-1:0] head_rep;

  // Hold buffer replay path: the back end reads, the front end owns the buffer.
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_byte;
  logic             replay_done;

  front_stat_t      front_stat;

  // Short names for the conditions checked by the assertions.
  logic             rep_pend;
  logic             scan_idle;
  logic             last_acc;
  logic             end_word;

  hepe_front #(
    .ENTITY_WINDOW (ENTITY_WINDOW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .fifo_full_i   (q_full),
    .replay_done_i (replay_done),
    .rd_idx_i      (rd_idx),
    .rd_byte_o     (rd_byte),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .rep_o         (push_rep),
    .stat_o        (front_stat)
  );

  hepe_cmd_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_cmd, push_rep}),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_head)
  );

  assign head_cmd = cmd_t'(q_head[ENTRY_W-1:CNT_W]);
  assign head_rep = q_head[CNT_W-1:0];

  hepe_back #(
    .ENTITY_WINDOW (ENTITY_WINDOW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .rep_i         (head_rep),
    .pop_o         (q_pop),
    .rd_idx_o      (rd_idx),
    .rd_byte_i     (rd_byte),
    .replay_done_o (replay_done),
    .out_o         (out_o)
  );

  assign rep_pend  = front_stat.replay_pend;
  assign scan_idle = front_stat.scan_idle;
  assign last_acc  = in_i.valid && in_i.ready && in_i.string_last;
  assign end_word  = out_o.valid && out_o.string_end;

  // A pending replay always has its command still waiting in the queue.
  `HEPE_ASSERT_SAME(a_pend_has_cmd, clk_i, rst_ni, rep_pend, q_valid, "replay without command")

  // The last word of a string always leaves the scan idle.
  `HEPE_ASSERT_NEXT(a_last_ends_scan, clk_i, rst_ni, last_acc, scan_idle, "scan open after last")

  // The end of the escaped string is also the end of its word's run.
  `HEPE_ASSERT_SAME(a_end_run_last, clk_i, rst_ni, end_word, out_o.run_last, "end without run end")

endmodule
